[src/disk_request_scheduler_assert.svh]
// ----------------------------------------------------------------------------
// Disk request scheduler assertion macros
// Shorthand for clocked checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef DISK_REQUEST_SCHEDULER_ASSERT_SVH
`define DISK_REQUEST_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define DRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/drs_pkg.sv]
// ----------------------------------------------------------------------------
// drs_pkg
// Types and constants shared by the disk request scheduler modules.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int TRACK_WIDTH = 16;
  localparam int TAG_WIDTH   = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int MODE_W      = 3;
  localparam int STATUS_W    = 2;

  localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DISPATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  localparam logic [MODE_W-1:0] MODE_FIFO  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SSTF  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOOK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLOOK = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FSCAN = 3'd4;

  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [0:0] REG_POLICY_MODE = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_EVAL,
    S_FINISH
  } drs_state_t;

  typedef enum logic [1:0] {
    K_FIRST,
    K_NEAR,
    K_LOW,
    K_HIGH
  } drs_kind_t;

  typedef enum logic [1:0] {
    SD_ANY,
    SD_UP,
    SD_DOWN
  } drs_side_t;

  typedef struct packed {
    logic [TRACK_WIDTH-1:0] trk;
    logic [TAG_WIDTH-1:0]   tag;
    logic                   act;
  } drs_entry_t;

  typedef struct packed {
    logic                   append;
    logic                   remove;
    logic                   activate;
    logic [IDX_W-1:0]       wr_idx;
    logic [IDX_W-1:0]       rm_idx;
    logic [TRACK_WIDTH-1:0] trk;
    logic [TAG_WIDTH-1:0]   tag;
  } drs_store_op_t;

  typedef struct packed {
    logic      clear;
    logic      step;
    drs_kind_t kind;
    drs_side_t side;
    logic      batched;
  } drs_pick_ctl_t;

endpackage

[src/drs_store.sv]
// ----------------------------------------------------------------------------
// drs_store
// Request slots kept in arrival order; append, remove with shift-down,
// batch activation and one indexed read port.
// ----------------------------------------------------------------------------
module drs_store (
  input  logic                           clk,
  input  drs_pkg::drs_store_op_t         op,
  input  logic [drs_pkg::IDX_W-1:0]      rd_idx,
  input  logic [drs_pkg::CNT_W-1:0]      cnt,
  output drs_pkg::drs_entry_t            rd_ent,
  output logic                           any_active
);

  logic [drs_pkg::TRACK_WIDTH-1:0] trk_r [drs_pkg::QUEUE_DEPTH];
  logic [drs_pkg::TAG_WIDTH-1:0]   tag_r [drs_pkg::QUEUE_DEPTH];
  logic                            act_r [drs_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    for (int j = 0; j < drs_pkg::QUEUE_DEPTH; j++) begin
      if (op.append && (op.wr_idx == drs_pkg::IDX_W'(j))) begin
        trk_r[j] <= op.trk;
        tag_r[j] <= op.tag;
        act_r[j] <= 1'b0;
      end else if (op.remove && (drs_pkg::IDX_W'(j) >= op.rm_idx) &&
                   (j < drs_pkg::QUEUE_DEPTH - 1)) begin
        trk_r[j] <= trk_r[(j + 1) % drs_pkg::QUEUE_DEPTH];
        tag_r[j] <= tag_r[(j + 1) % drs_pkg::QUEUE_DEPTH];
        act_r[j] <= act_r[(j + 1) % drs_pkg::QUEUE_DEPTH];
      end else if (op.activate) begin
        act_r[j] <= 1'b1;
      end
    end
  end

  always_comb begin
    rd_ent.trk = trk_r[rd_idx];
    rd_ent.tag = tag_r[rd_idx];
    rd_ent.act = act_r[rd_idx];
  end

  always_comb begin
    any_active = 1'b0;
    for (int j = 0; j < drs_pkg::QUEUE_DEPTH; j++) begin
      if (act_r[j] && (drs_pkg::CNT_W'(j) < cnt)) begin
        any_active = 1'b1;
      end
    end
  end

endmodule

[src/drs_pick.sv]
// ----------------------------------------------------------------------------
// drs_pick
// Shared compare unit: looks at one slot per cycle when stepped, keeps the best so far.
// ----------------------------------------------------------------------------
module drs_pick (
  input  logic                              clk,
  input  logic                              rst_n,
  input  drs_pkg::drs_pick_ctl_t            ctl,
  input  logic [drs_pkg::TRACK_WIDTH-1:0]   head,
  input  logic [drs_pkg::IDX_W-1:0]         idx,
  input  drs_pkg::drs_entry_t               ent,
  output logic                              found,
  output logic [drs_pkg::IDX_W-1:0]         best_idx,
  output logic [drs_pkg::TRACK_WIDTH-1:0]   best_trk,
  output logic [drs_pkg::TAG_WIDTH-1:0]     best_tag
);

  logic                            found_r;
  logic [drs_pkg::IDX_W-1:0]       idx_r;
  logic [drs_pkg::TRACK_WIDTH-1:0] trk_r;
  logic [drs_pkg::TAG_WIDTH-1:0]   tag_r;
  logic [drs_pkg::TRACK_WIDTH-1:0] seek_len_r;
  logic [drs_pkg::TRACK_WIDTH-1:0] seek_len;
  logic                            ge_head;
  logic                            ok;
  logic                            better;

  always_comb begin
    ge_head  = (ent.trk >= head);
    seek_len = ge_head ? (ent.trk - head) : (head - ent.trk);
    ok       = (!ctl.batched || ent.act);
    case (ctl.side)
      drs_pkg::SD_UP:   ok = ok && ge_head;
      drs_pkg::SD_DOWN: ok = ok && (ent.trk <= head);
      default:          ok = ok;
    endcase
    case (ctl.kind)
      drs_pkg::K_NEAR: better = !found_r || (seek_len < seek_len_r);
      drs_pkg::K_LOW:  better = !found_r || (ent.trk < trk_r);
      drs_pkg::K_HIGH: better = !found_r || (ent.trk >= trk_r);
      default:         better = !found_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      found_r <= 1'b0;
    end else if (ctl.step && ok && better) begin
      found_r <= 1'b1;
    end
    if (ctl.step && ok && better) begin
      idx_r      <= idx;
      trk_r      <= ent.trk;
      tag_r      <= ent.tag;
      seek_len_r <= seek_len;
    end
  end

  assign found    = found_r;
  assign best_idx = idx_r;
  assign best_trk = trk_r;
  assign best_tag = tag_r;

endmodule

[src/disk_request_scheduler.sv]
// ----------------------------------------------------------------------------
// disk_request_scheduler
// Holds up to 32 disk requests and hands them out under a selectable policy.
// ----------------------------------------------------------------------------
// An add passes from acceptance through the setup and finish states to the
// result beat. A dispatch walks the held requests one slot per cycle through a
// single compare unit, and walks them a second time when a look sweep turns
// around or a circular look wraps. in_stall stays high until the result beat
// has been loaded into the output register.
module disk_request_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic [drs_pkg::TRACK_WIDTH-1:0]   in_request_track,
  input  logic [drs_pkg::TAG_WIDTH-1:0]     in_request_tag,
  input  logic [drs_pkg::TRACK_WIDTH-1:0]   in_head_track,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [drs_pkg::STATUS_W-1:0]      out_status,
  output logic [drs_pkg::TAG_WIDTH-1:0]     out_chosen_tag,
  output logic [drs_pkg::TRACK_WIDTH-1:0]   out_chosen_track,
  output logic [drs_pkg::CNT_W-1:0]         out_pending_total,
  output logic                              out_all_done,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  drs_pkg::drs_state_t state_r, state_nxt;

  logic [drs_pkg::MODE_W-1:0]      mode_r;
  logic [drs_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            sweep_r, sweep_nxt;
  logic                            cmd_r;
  logic [drs_pkg::TRACK_WIDTH-1:0] rtrk_r;
  logic [drs_pkg::TAG_WIDTH-1:0]   rtag_r;
  logic [drs_pkg::TRACK_WIDTH-1:0] head_r;
  logic [drs_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic                            pass_r, pass_nxt;
  drs_pkg::drs_kind_t              kind_r, kind_nxt;
  drs_pkg::drs_side_t              side_r, side_nxt;
  logic                            batch_r, batch_nxt;
  logic [drs_pkg::STATUS_W-1:0]    rstat_r, rstat_nxt;
  logic [drs_pkg::TAG_WIDTH-1:0]   rtago_r, rtago_nxt;
  logic [drs_pkg::TRACK_WIDTH-1:0] rtrko_r, rtrko_nxt;

  logic                            out_valid_r;
  logic [drs_pkg::STATUS_W-1:0]    out_status_r;
  logic [drs_pkg::TAG_WIDTH-1:0]   out_tag_r;
  logic [drs_pkg::TRACK_WIDTH-1:0] out_trk_r;
  logic [drs_pkg::CNT_W-1:0]       out_cnt_r;

  drs_pkg::drs_store_op_t          sop;
  drs_pkg::drs_pick_ctl_t          pctl;
  drs_pkg::drs_entry_t             rd_ent;
  logic                            any_active;
  logic                            found;
  logic [drs_pkg::IDX_W-1:0]       best_idx;
  logic [drs_pkg::TRACK_WIDTH-1:0] best_trk;
  logic [drs_pkg::TAG_WIDTH-1:0]   best_tag;

  logic in_acc;
  logic out_free;
  logic last_slot;
  logic sweep_eff;
  logic cfg_wr;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_slot = ({1'b0, idx_r} == (cnt_r - drs_pkg::CNT_W'(1)));
  assign in_stall  = (state_r != drs_pkg::S_IDLE);

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == drs_pkg::REG_POLICY_MODE) ?
                  {{(32 - drs_pkg::MODE_W){1'b0}}, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= drs_pkg::MODE_FIFO;
    end else if (cfg_wr && (paddr[2] == drs_pkg::REG_POLICY_MODE)) begin
      mode_r <= pwdata[drs_pkg::MODE_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      drs_pkg::S_IDLE: begin
        if (in_acc) state_nxt = drs_pkg::S_SETUP;
      end
      drs_pkg::S_SETUP: begin
        if (cmd_r == drs_pkg::CMD_ADD || cnt_r == '0) state_nxt = drs_pkg::S_EVAL;
        else                                            state_nxt = drs_pkg::S_SCAN;
        if (cmd_r == drs_pkg::CMD_ADD) state_nxt = drs_pkg::S_FINISH;
      end
      drs_pkg::S_SCAN: begin
        if (last_slot) state_nxt = drs_pkg::S_EVAL;
      end
      drs_pkg::S_EVAL: begin
        if (!found && !pass_r && (mode_r == drs_pkg::MODE_LOOK ||
            mode_r == drs_pkg::MODE_CLOOK || mode_r == drs_pkg::MODE_FSCAN)) begin
          state_nxt = (cnt_r == '0) ? drs_pkg::S_EVAL : drs_pkg::S_SCAN;
        end else begin
          state_nxt = drs_pkg::S_FINISH;
        end
      end
      drs_pkg::S_FINISH: begin
        if (out_free) state_nxt = drs_pkg::S_IDLE;
      end
      default: state_nxt = drs_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    cnt_nxt   = cnt_r;
    sweep_nxt = sweep_r;
    idx_nxt   = idx_r;
    pass_nxt  = pass_r;
    kind_nxt  = kind_r;
    side_nxt  = side_r;
    batch_nxt = batch_r;
    rstat_nxt = rstat_r;
    rtago_nxt = rtago_r;
    rtrko_nxt = rtrko_r;
    sop.append   = 1'b0;
    sop.remove   = 1'b0;
    sop.activate = 1'b0;
    sop.wr_idx   = cnt_r[drs_pkg::IDX_W-1:0];
    sop.rm_idx   = best_idx;
    sop.trk      = rtrk_r;
    sop.tag      = rtag_r;
    pctl.clear   = 1'b0;
    pctl.step    = 1'b0;
    pctl.kind    = kind_r;
    pctl.side    = side_r;
    pctl.batched = batch_r;
    sweep_eff    = sweep_r;
    unique case (state_r)
      drs_pkg::S_SETUP: begin
        rtago_nxt = '0;
        rtrko_nxt = '0;
        idx_nxt   = '0;
        pass_nxt  = 1'b0;
        if (cmd_r == drs_pkg::CMD_ADD) begin
          if (cnt_r == drs_pkg::CNT_W'(drs_pkg::QUEUE_DEPTH)) begin
            rstat_nxt = drs_pkg::ST_FULL;
          end else begin
            sop.append = 1'b1;
            cnt_nxt    = cnt_r + drs_pkg::CNT_W'(1);
            rstat_nxt  = drs_pkg::ST_ADDED;
          end
        end else begin
          pctl.clear = 1'b1;
          batch_nxt  = 1'b0;
          if (mode_r == drs_pkg::MODE_FSCAN && !any_active) begin
            sop.activate = 1'b1;
            sweep_eff    = 1'b1;
            sweep_nxt    = 1'b1;
          end
          case (mode_r)
            drs_pkg::MODE_SSTF: begin
              kind_nxt = drs_pkg::K_NEAR;
              side_nxt = drs_pkg::SD_ANY;
            end
            drs_pkg::MODE_LOOK, drs_pkg::MODE_FSCAN: begin
              kind_nxt  = sweep_eff ? drs_pkg::K_LOW : drs_pkg::K_HIGH;
              side_nxt  = sweep_eff ? drs_pkg::SD_UP : drs_pkg::SD_DOWN;
              batch_nxt = (mode_r == drs_pkg::MODE_FSCAN);
            end
            drs_pkg::MODE_CLOOK: begin
              kind_nxt = drs_pkg::K_LOW;
              side_nxt = drs_pkg::SD_UP;
            end
            default: begin
              kind_nxt = drs_pkg::K_FIRST;
              side_nxt = drs_pkg::SD_ANY;
            end
          endcase
        end
      end
      drs_pkg::S_SCAN: begin
        pctl.step = 1'b1;
        idx_nxt   = idx_r + drs_pkg::IDX_W'(1);
      end
      drs_pkg::S_EVAL: begin
        idx_nxt = '0;
        if (found) begin
          sop.remove = 1'b1;
          cnt_nxt    = cnt_r - drs_pkg::CNT_W'(1);
          rstat_nxt  = drs_pkg::ST_DISPATCH;
          rtago_nxt  = best_tag;
          rtrko_nxt  = best_trk;
        end else if (!pass_r && (mode_r == drs_pkg::MODE_LOOK ||
                     mode_r == drs_pkg::MODE_CLOOK || mode_r == drs_pkg::MODE_FSCAN)) begin
          pctl.clear = 1'b1;
          pass_nxt   = 1'b1;
          side_nxt   = drs_pkg::SD_ANY;
          if (mode_r == drs_pkg::MODE_CLOOK) begin
            kind_nxt = drs_pkg::K_LOW;
          end else begin
            kind_nxt  = sweep_r ? drs_pkg::K_HIGH : drs_pkg::K_LOW;
            sweep_nxt = !sweep_r;
          end
        end else begin
          rstat_nxt = drs_pkg::ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drs_pkg::S_IDLE;
      cnt_r       <= '0;
      sweep_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sweep_r <= sweep_nxt;
      if (state_r == drs_pkg::S_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_command;
      rtrk_r <= in_request_track;
      rtag_r <= in_request_tag;
      head_r <= in_head_track;
    end
    idx_r   <= idx_nxt;
    pass_r  <= pass_nxt;
    kind_r  <= kind_nxt;
    side_r  <= side_nxt;
    batch_r <= batch_nxt;
    rstat_r <= rstat_nxt;
    rtago_r <= rtago_nxt;
    rtrko_r <= rtrko_nxt;
    if (state_r == drs_pkg::S_FINISH && out_free) begin
      out_status_r <= rstat_r;
      out_tag_r    <= rtago_r;
      out_trk_r    <= rtrko_r;
      out_cnt_r    <= cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_chosen_tag    = out_tag_r;
  assign out_chosen_track  = out_trk_r;
  assign out_pending_total = out_cnt_r;
  assign out_all_done      = (out_cnt_r == '0);

  drs_store u_store (
    .clk        (clk),
    .op         (sop),
    .rd_idx     (idx_r),
    .cnt        (cnt_r),
    .rd_ent     (rd_ent),
    .any_active (any_active)
  );

  drs_pick u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (pctl),
    .head     (head_r),
    .idx      (idx_r),
    .ent      (rd_ent),
    .found    (found),
    .best_idx (best_idx),
    .best_trk (best_trk),
    .best_tag (best_tag)
  );

`include "disk_request_scheduler_assert.svh"

  `DRS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= drs_pkg::CNT_W'(drs_pkg::QUEUE_DEPTH), "count overflow")
  `DRS_ASSERT_NEXT(a_accept_setup, in_acc, state_r == drs_pkg::S_SETUP, "accept without setup")
  `DRS_ASSERT_NOW(a_beat_from_finish, $rose(out_valid_r), $past(state_r) == drs_pkg::S_FINISH, "stray result beat")

endmodule

[sim/disk_request_scheduler_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Disk request scheduler testbench
// Drives add and dispatch beats under every policy, predicts each result beat
// with a behavioral queue model and checks the beats in order, with random
// gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module disk_request_scheduler_tb;
  import drs_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_command;
  logic [TRACK_WIDTH-1:0] in_request_track;
  logic [TAG_WIDTH-1:0]   in_request_tag;
  logic [TRACK_WIDTH-1:0] in_head_track;
  logic                   out_valid;
  logic                   out_stall;
  logic [STATUS_W-1:0]    out_status;
  logic [TAG_WIDTH-1:0]   out_chosen_tag;
  logic [TRACK_WIDTH-1:0] out_chosen_track;
  logic [CNT_W-1:0]       out_pending_total;
  logic                   out_all_done;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [2:0]             paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [TAG_WIDTH-1:0]   tag;
    logic [TRACK_WIDTH-1:0] trk;
    logic [CNT_W-1:0]       total;
    logic                   done;
  } sched_result_t;

  sched_result_t          pending_results[$];
  logic [TRACK_WIDTH-1:0] q_trk[$];
  logic [TAG_WIDTH-1:0]   q_tag[$];
  logic                   q_act[$];
  logic                   sweep_up;
  logic [MODE_W-1:0]      mode;
  int                     errors;
  int                     cycles;
  bit                     hold_out;
  bit                     no_gaps;
  int                     hold_cycles;

  disk_request_scheduler i_dut (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // sorted order: ascending track, then arrival
  function automatic bit precedes(int a, int b);
    if (q_trk[a] != q_trk[b]) return q_trk[a] < q_trk[b];
    return a < b;
  endfunction

  function automatic int extreme_of(bit lowest, int side, logic [TRACK_WIDTH-1:0] head,
                                    bit batched);
    int best;
    best = -1;
    for (int i = 0; i < q_trk.size(); i++) begin
      if (batched && !q_act[i]) continue;
      if (side > 0 && q_trk[i] < head) continue;
      if (side < 0 && q_trk[i] > head) continue;
      if (best < 0) best = i;
      else if (lowest ? precedes(i, best) : precedes(best, i)) best = i;
    end
    return best;
  endfunction

  function automatic int look_pick(logic [TRACK_WIDTH-1:0] head, bit batched);
    int k;
    if (sweep_up) begin
      k = extreme_of(1, 1, head, batched);
      if (k < 0) begin
        sweep_up = 0;
        k = extreme_of(0, 0, head, batched);
      end
    end else begin
      k = extreme_of(0, -1, head, batched);
      if (k < 0) begin
        sweep_up = 1;
        k = extreme_of(1, 0, head, batched);
      end
    end
    return k;
  endfunction

  function automatic sched_result_t predict_schedule(logic cmd, logic [TRACK_WIDTH-1:0] trk,
                                                     logic [TAG_WIDTH-1:0] tag,
                                                     logic [TRACK_WIDTH-1:0] head);
    sched_result_t r;
    int k;
    int d;
    int bd;
    r = '0;
    if (cmd == CMD_ADD) begin
      if (q_trk.size() >= QUEUE_DEPTH) r.status = ST_FULL;
      else begin
        q_trk.insert(q_trk.size(), trk);
        q_tag.insert(q_tag.size(), tag);
        q_act.insert(q_act.size(), 1'b0);
        r.status = ST_ADDED;
      end
    end else begin
      case (mode)
        MODE_SSTF: begin
          k = -1;
          bd = 0;
          for (int i = 0; i < q_trk.size(); i++) begin
            d = (q_trk[i] >= head) ? q_trk[i] - head : head - q_trk[i];
            if (k < 0 || d < bd) begin
              k = i;
              bd = d;
            end
          end
        end
        MODE_LOOK: k = look_pick(head, 0);
        MODE_CLOOK: begin
          k = extreme_of(1, 1, head, 0);
          if (k < 0) k = extreme_of(1, 0, head, 0);
        end
        MODE_FSCAN: begin
          if (extreme_of(1, 0, head, 1) < 0) begin
            foreach (q_act[i]) q_act[i] = 1'b1;
            sweep_up = 1;
          end
          k = look_pick(head, 1);
        end
        default: k = (q_trk.size() > 0) ? 0 : -1;
      endcase
      if (k < 0) r.status = ST_EMPTY;
      else begin
        r.status = ST_DISPATCH;
        r.trk = q_trk[k];
        r.tag = q_tag[k];
        q_trk.delete(k);
        q_tag.delete(k);
        q_act.delete(k);
      end
    end
    r.total = CNT_W'(q_trk.size());
    r.done = (q_trk.size() == 0);
    return r;
  endfunction

  task automatic send_request(input logic cmd, input logic [TRACK_WIDTH-1:0] trk,
                              input logic [TAG_WIDTH-1:0] tag,
                              input logic [TRACK_WIDTH-1:0] head);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_request_track <= trk;
    in_request_tag <= tag;
    in_head_track <= head;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.insert(pending_results.size(), predict_schedule(cmd, trk, tag, head));
  endtask

  task automatic end_of_beats();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    end_of_beats();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {1'b0, REG_POLICY_MODE, 2'b00};
    pwdata <= 32'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mode = m;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) report("unexpected beat", out_status, -1);
      else begin
        sched_result_t e;
        e = pending_results.pop_front();
        if (out_status !== e.status) report("status", out_status, e.status);
        if (out_chosen_tag !== e.tag) report("chosen_tag", out_chosen_tag, e.tag);
        if (out_chosen_track !== e.trk) report("chosen_track", out_chosen_track, e.trk);
        if (out_pending_total !== e.total) report("pending_total", out_pending_total, e.total);
        if (out_all_done !== e.done) report("all_done", out_all_done, e.done);
      end
    end
  end

  // stall pattern on the result side
  always @(posedge clk) begin
    if (hold_out) out_stall <= 1'b1;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (no_gaps) out_stall <= 1'b0;
    else begin
      out_stall <= ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) hold_cycles <= $urandom_range(0, 16);
    end
  end

  task automatic rand_add();
    send_request(CMD_ADD, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15) * 1000)
                 : 16'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic rand_dispatch();
    send_request(CMD_DISPATCH, 16'($urandom), 8'($urandom),
                 ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 15) * 1000)
                 : 16'($urandom));
  endtask

  task automatic test_directed();
    send_request(CMD_DISPATCH, 16'hFFFF, 8'hFF, 16'h0000);
    send_request(CMD_ADD, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_request(CMD_ADD, 16'h0000, 8'h00, 16'h0000);
    send_request(CMD_ADD, 16'h8000, 8'h5A, 16'h0000);
    send_request(CMD_ADD, 16'h8000, 8'hA5, 16'h0000);
    for (int m = 0; m < 8; m++) begin
      write_mode(MODE_W'(m));
      send_request(CMD_ADD, 16'h8000, 8'(m), 16'h0);
      send_request(CMD_DISPATCH, 16'h0, 8'h0, 16'h8000);
      send_request(CMD_DISPATCH, 16'h0, 8'h0, 16'hFFFF);
    end
  endtask

  task automatic test_full_store();
    write_mode(MODE_FIFO);
    for (int i = 0; i < QUEUE_DEPTH + 2; i++) rand_add();
    for (int i = 0; i < QUEUE_DEPTH + 1; i++) rand_dispatch();
  endtask

  task automatic test_random_policies(input int beats);
    for (int p = 0; p < beats / 80; p++) begin
      write_mode(MODE_W'($urandom_range(0, 7)));
      no_gaps = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < 80; i++) begin
        if ($urandom_range(0, 99) < (q_trk.size() < 4 ? 75 : 45)) rand_add();
        else rand_dispatch();
      end
      no_gaps = 0;
    end
  endtask

  task automatic test_backpressure();
    write_mode(MODE_FSCAN);
    hold_out = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_out = 0;
      end
      for (int i = 0; i < 12; i++) begin
        if (i % 3 == 2) rand_dispatch();
        else rand_add();
      end
    join
    end_of_beats();
    for (int i = 0; i < 10; i++) rand_dispatch();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_ADD;
    in_request_track = '0;
    in_request_tag = '0;
    in_head_track = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycles = 0;
    hold_out = 0;
    no_gaps = 0;
    hold_cycles = 0;
    sweep_up = 1;
    mode = MODE_FIFO;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_backpressure();
    test_random_policies(640);
    end_of_beats();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
